// ----- rtl/core/lsf_pkg.sv -----
// ----------------------------------------------------------------------------
// lsf_pkg
// shared constants for the least squares line fit unit
// ----------------------------------------------------------------------------
`default_nettype none

package lsf_pkg;

  // opcodes
  localparam logic [1:0] OP_APPEND   = 2'd0;
  localparam logic [1:0] OP_CLEAR    = 2'd1;
  localparam logic [1:0] OP_FIT      = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam int NUM_CHANNELS   = 2;
  localparam int MAX_POINTS_DEF = 256;

  // working width of sums, products and quotients
  localparam int WW = 128;

  localparam logic [47:0] ONE_Q24 = 48'h00_0001_000000;
  localparam logic [16:0] Q_ONE   = 17'h10000;

endpackage

`default_nettype wire

// ----- rtl/core/lsf_mul.sv -----
// ----------------------------------------------------------------------------
// lsf_mul
// signed multiplier, 128 by 64 bits modulo 2^128, built from one 32x32 unit
// stepped over limb pairs; upper zero limbs are skipped
// ----------------------------------------------------------------------------
`default_nettype none

module lsf_mul (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [127:0] a_i,
  input  wire logic [63:0]  b_i,
  output logic              done_o,
  output logic [127:0]      prod_o
);

  typedef enum logic [1:0] {M_IDLE, M_MUL, M_ADD, M_SIGN} mul_state_e;

  mul_state_e   state_q;
  logic [127:0] am_q;
  logic [63:0]  bm_q;
  logic         neg_q;
  logic [1:0]   i_q;
  logic         j_q;
  logic [63:0]  pp_q;
  logic [127:0] acc_q;
  logic         done_q;

  logic [1:0]  la;
  logic        lb;
  logic [31:0] a_l;
  logic [31:0] b_l;
  logic [63:0] pp;
  logic [7:0]  sh;

  always_comb begin
    if (am_q[127:96] != '0) begin
      la = 2'd3;
    end else if (am_q[95:64] != '0) begin
      la = 2'd2;
    end else if (am_q[63:32] != '0) begin
      la = 2'd1;
    end else begin
      la = 2'd0;
    end
  end

  assign lb  = (bm_q[63:32] != '0);
  assign a_l = am_q[32*i_q +: 32];
  assign b_l = bm_q[32*j_q +: 32];
  assign pp  = a_l * b_l;
  assign sh  = {3'(i_q) + 3'(j_q), 5'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      am_q    <= '0;
      bm_q    <= '0;
      neg_q   <= 1'b0;
      i_q     <= '0;
      j_q     <= 1'b0;
      pp_q    <= '0;
      acc_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        M_IDLE: begin
          if (start_i) begin
            am_q    <= a_i[127] ? (~a_i + 128'd1) : a_i;
            bm_q    <= b_i[63] ? (~b_i + 64'd1) : b_i;
            neg_q   <= a_i[127] ^ b_i[63];
            i_q     <= '0;
            j_q     <= 1'b0;
            acc_q   <= '0;
            state_q <= M_MUL;
          end
        end
        M_MUL: begin
          pp_q    <= pp;
          state_q <= M_ADD;
        end
        M_ADD: begin
          acc_q <= acc_q + (128'(pp_q) << sh);
          if (j_q < lb) begin
            j_q     <= 1'b1;
            state_q <= M_MUL;
          end else if (i_q < la) begin
            i_q     <= i_q + 2'd1;
            j_q     <= 1'b0;
            state_q <= M_MUL;
          end else begin
            state_q <= M_SIGN;
          end
        end
        M_SIGN: begin
          if (neg_q) begin
            acc_q <= ~acc_q + 128'd1;
          end
          done_q  <= 1'b1;
          state_q <= M_IDLE;
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

// ----- rtl/core/lsf_div.sv -----
// ----------------------------------------------------------------------------
// lsf_div
// signed 128-bit divider, rounds to nearest with ties away from zero,
// restoring, one quotient bit per cycle; a zero divisor gives zero
// ----------------------------------------------------------------------------
`default_nettype none

module lsf_div (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [127:0] a_i,
  input  wire logic [127:0] b_i,
  output logic              done_o,
  output logic [127:0]      quo_o
);

  typedef enum logic [1:0] {D_IDLE, D_ADD, D_LOOP, D_SIGN} div_state_e;

  div_state_e   state_q;
  logic [127:0] ua_q;
  logic [127:0] ub_q;
  logic [127:0] n_q;
  logic [127:0] r_q;
  logic [6:0]   cnt_q;
  logic         neg_q;
  logic         done_q;
  logic [127:0] quo_q;

  logic [128:0] rr;
  logic [128:0] diff;
  logic         qbit;

  assign rr   = {r_q, n_q[127]};
  assign diff = rr - {1'b0, ub_q};
  assign qbit = !diff[128];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      ua_q    <= '0;
      ub_q    <= '0;
      n_q     <= '0;
      r_q     <= '0;
      cnt_q   <= '0;
      neg_q   <= 1'b0;
      done_q  <= 1'b0;
      quo_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        D_IDLE: begin
          if (start_i) begin
            ua_q    <= a_i[127] ? (~a_i + 128'd1) : a_i;
            ub_q    <= b_i[127] ? (~b_i + 128'd1) : b_i;
            neg_q   <= a_i[127] ^ b_i[127];
            state_q <= D_ADD;
          end
        end
        D_ADD: begin
          // bias by half the divisor for rounding
          n_q     <= ua_q + (ub_q >> 1);
          r_q     <= '0;
          cnt_q   <= 7'd127;
          state_q <= D_LOOP;
        end
        D_LOOP: begin
          r_q   <= qbit ? diff[127:0] : rr[127:0];
          n_q   <= {n_q[126:0], qbit};
          cnt_q <= cnt_q - 7'd1;
          if (cnt_q == '0) begin
            state_q <= D_SIGN;
          end
        end
        D_SIGN: begin
          if (ub_q == '0) begin
            quo_q <= '0;
          end else if (neg_q) begin
            quo_q <= ~n_q + 128'd1;
          end else begin
            quo_q <= n_q;
          end
          done_q  <= 1'b1;
          state_q <= D_IDLE;
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// ----- rtl/core/least_squares_line_fit_unit.sv -----
// ----------------------------------------------------------------------------
// least_squares_line_fit_unit
// per-channel calibration point stores with a least squares line fit,
// slope, offset and r squared computed by a shared multiplier and divider
// ----------------------------------------------------------------------------
// channel | handshake             | payload
// in      | in_valid_i/in_ready_o | opcode_i channel_i raw_value_i actual_value_i
// out     | out_valid_o/out_ready_i | point_count_o slope_o offset_o
//         |                       | fit_quality_o degenerate_o
//
// append and clear complete without leaving idle; a fit with under two points
// goes straight to the finish state, and a longer fit takes a first pass over
// the points, a residual pass and up to three divisions (slope, offset, quality)
// in_ready_o is low for the whole fit; a result waits in the output register
// while new transactions are taken, and a later fit holds until it frees
// reset empties both channels; point memory needs no clearing
// ----------------------------------------------------------------------------
`default_nettype none

module least_squares_line_fit_unit #(
  parameter int MAX_POINTS = lsf_pkg::MAX_POINTS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         opcode_i,
  input  wire logic               channel_i,
  input  wire logic signed [31:0] raw_value_i,
  input  wire logic signed [31:0] actual_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [8:0]              point_count_o,
  output logic signed [47:0]      slope_o,
  output logic signed [31:0]      offset_o,
  output logic [16:0]             fit_quality_o,
  output logic                    degenerate_o
);

  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int IW    = $clog2(MAX_POINTS);
  localparam int DEPTH = lsf_pkg::NUM_CHANNELS * MAX_POINTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int SXW   = 32 + CW;
  localparam int SQW   = 64 + CW;
  localparam int W     = lsf_pkg::WW;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_MULGO, ST_MULW, ST_RES1, ST_RES2, ST_CHK,
    ST_DIVGO, ST_DIVW, ST_FIN
  } state_e;

  typedef enum logic [3:0] {
    SP_X2, SP_XY, SP_Y2, SP_D1, SP_D2, SP_N1, SP_N2, SP_SL,
    SP_O1, SP_OF, SP_R1, SP_R2, SP_T1, SP_T2, SP_Q1, SP_QD
  } step_e;

  function automatic logic [47:0] sat48(input logic [W-1:0] v);
    if ((&v[W-1:47]) || !(|v[W-1:47])) begin
      return v[47:0];
    end
    return v[W-1] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
  endfunction

  function automatic logic [31:0] sat32(input logic [W-1:0] v);
    if ((&v[W-1:31]) || !(|v[W-1:31])) begin
      return v[31:0];
    end
    return v[W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  state_e             state_q;
  step_e              step_q;
  logic [CW-1:0]      cnt_q [lsf_pkg::NUM_CHANNELS];
  logic               ch_q;
  logic [CW-1:0]      n_q;
  logic [CW-1:0]      idx_q;
  logic [SXW-1:0]     sx_q;
  logic [SXW-1:0]     sy_q;
  logic [SQW-1:0]     sxx_q;
  logic [SQW-1:0]     sxy_q;
  logic [SQW-1:0]     syy_q;
  logic [W-1:0]       tmp_q;
  logic [W-1:0]       num_q;
  logic [W-1:0]       den_q;
  logic [W-1:0]       d_q;
  logic [W-1:0]       ssr_q;
  logic [W-25:0]      rm_q;
  logic               dneg_q;
  logic [63:0]        e_q;
  logic [47:0]        slope_w_q;
  logic [31:0]        offset_w_q;
  logic [16:0]        qual_w_q;
  logic               degen_w_q;
  logic               out_valid_q;
  logic [8:0]         point_count_q;
  logic [47:0]        slope_q;
  logic [31:0]        offset_q;
  logic [16:0]        quality_q;
  logic               degen_q;

  logic [63:0]        store_mem [DEPTH];
  logic [63:0]        rd_q;

  // memory access
  logic [CW-1:0] in_cnt;
  logic          mem_we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  assign in_cnt = cnt_q[channel_i];
  assign mem_we = (state_q == ST_IDLE) && in_valid_i && (opcode_i == lsf_pkg::OP_APPEND) &&
                  (in_cnt < CW'(MAX_POINTS));
  assign waddr  = (channel_i ? AW'(MAX_POINTS) : '0) + AW'(in_cnt[IW-1:0]);
  assign raddr  = (ch_q ? AW'(MAX_POINTS) : '0) + AW'(idx_q[IW-1:0]);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[waddr] <= {raw_value_i, actual_value_i};
    end
    if (state_q == ST_RD) begin
      rd_q <= store_mem[raddr];
    end
  end

  // operand views
  logic [31:0]  px;
  logic [31:0]  py;
  logic [W-1:0] x_ext;
  logic [W-1:0] y_ext;
  logic [W-1:0] sx_ext;
  logic [W-1:0] sy_ext;
  logic [W-1:0] sxx_ext;
  logic [W-1:0] sxy_ext;
  logic [W-1:0] syy_ext;
  logic [W-1:0] off_ext;
  logic [W-1:0] n_ext;
  logic [63:0]  n64;
  logic [63:0]  sx64;
  logic [63:0]  sy64;
  logic [63:0]  slope64;

  assign px      = rd_q[63:32];
  assign py      = rd_q[31:0];
  assign x_ext   = {{(W-32){px[31]}}, px};
  assign y_ext   = {{(W-32){py[31]}}, py};
  assign sx_ext  = {{(W-SXW){sx_q[SXW-1]}}, sx_q};
  assign sy_ext  = {{(W-SXW){sy_q[SXW-1]}}, sy_q};
  assign sxx_ext = {{(W-SQW){1'b0}}, sxx_q};
  assign sxy_ext = {{(W-SQW){sxy_q[SQW-1]}}, sxy_q};
  assign syy_ext = {{(W-SQW){1'b0}}, syy_q};
  assign off_ext = {{(W-32){offset_w_q[31]}}, offset_w_q};
  assign n_ext   = {{(W-CW){1'b0}}, n_q};
  assign n64     = {{(64-CW){1'b0}}, n_q};
  assign sx64    = {{(64-SXW){sx_q[SXW-1]}}, sx_q};
  assign sy64    = {{(64-SXW){sy_q[SXW-1]}}, sy_q};
  assign slope64 = {{16{slope_w_q[47]}}, slope_w_q};

  // shared multiplier
  logic [W-1:0] mul_a;
  logic [63:0]  mul_b;
  logic         mul_done;
  logic [W-1:0] prod;

  always_comb begin
    case (step_q)
      SP_X2:   begin mul_a = x_ext;                   mul_b = x_ext[63:0]; end
      SP_XY:   begin mul_a = x_ext;                   mul_b = y_ext[63:0]; end
      SP_Y2:   begin mul_a = y_ext;                   mul_b = y_ext[63:0]; end
      SP_D1:   begin mul_a = sxx_ext;                 mul_b = n64; end
      SP_D2:   begin mul_a = sx_ext;                  mul_b = sx64; end
      SP_N1:   begin mul_a = sxy_ext;                 mul_b = n64; end
      SP_N2:   begin mul_a = sx_ext;                  mul_b = sy64; end
      SP_O1:   begin mul_a = sx_ext;                  mul_b = slope64; end
      SP_R1:   begin mul_a = x_ext;                   mul_b = slope64; end
      SP_R2:   begin mul_a = {{64{e_q[63]}}, e_q};    mul_b = e_q; end
      SP_T1:   begin mul_a = syy_ext;                 mul_b = n64; end
      SP_T2:   begin mul_a = sy_ext;                  mul_b = sy64; end
      SP_Q1:   begin mul_a = ssr_q;                   mul_b = n64; end
      default: begin mul_a = '0;                      mul_b = '0; end
    endcase
  end

  lsf_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_MULGO),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  // shared divider
  logic [W-1:0] div_a;
  logic [W-1:0] div_b;
  logic         div_done;
  logic [W-1:0] quo;

  always_comb begin
    case (step_q)
      SP_SL:   begin div_a = num_q << 24; div_b = den_q; end
      SP_OF:   begin div_a = tmp_q;       div_b = n_ext << 24; end
      SP_QD:   begin div_a = num_q;       div_b = tmp_q; end
      default: begin div_a = '0;          div_b = '0; end
    endcase
  end

  lsf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_DIVGO),
    .a_i     (div_a),
    .b_i     (div_b),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // residual rounding: magnitude plus half, shifted down by 24
  logic [W-1:0] rnd_sum;
  assign rnd_sum = d_q[W-1] ? (~d_q + W'(2**23 + 1)) : (d_q + W'(2**23));

  logic [CW-1:0] idx_nxt;
  assign idx_nxt = idx_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      step_q        <= SP_X2;
      for (int c = 0; c < lsf_pkg::NUM_CHANNELS; c++) begin
        cnt_q[c] <= '0;
      end
      ch_q          <= 1'b0;
      n_q           <= '0;
      idx_q         <= '0;
      sx_q          <= '0;
      sy_q          <= '0;
      sxx_q         <= '0;
      sxy_q         <= '0;
      syy_q         <= '0;
      tmp_q         <= '0;
      num_q         <= '0;
      den_q         <= '0;
      d_q           <= '0;
      ssr_q         <= '0;
      rm_q          <= '0;
      dneg_q        <= 1'b0;
      e_q           <= '0;
      slope_w_q     <= lsf_pkg::ONE_Q24;
      offset_w_q    <= '0;
      qual_w_q      <= '0;
      degen_w_q     <= 1'b1;
      out_valid_q   <= 1'b0;
      point_count_q <= '0;
      slope_q       <= '0;
      offset_q      <= '0;
      quality_q     <= '0;
      degen_q       <= 1'b0;
    end else begin
      // the fit state reloads the output register itself
      if (out_valid_q && out_ready_i && (state_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            case (opcode_i)
              lsf_pkg::OP_APPEND: begin
                if (in_cnt < CW'(MAX_POINTS)) begin
                  cnt_q[channel_i] <= in_cnt + 1'b1;
                end
              end
              lsf_pkg::OP_CLEAR: begin
                cnt_q[channel_i] <= '0;
              end
              lsf_pkg::OP_FIT: begin
                ch_q       <= channel_i;
                n_q        <= in_cnt;
                idx_q      <= '0;
                sx_q       <= '0;
                sy_q       <= '0;
                sxx_q      <= '0;
                sxy_q      <= '0;
                syy_q      <= '0;
                slope_w_q  <= lsf_pkg::ONE_Q24;
                offset_w_q <= '0;
                qual_w_q   <= '0;
                degen_w_q  <= 1'b1;
                if (in_cnt < CW'(2)) begin
                  state_q <= ST_FIN;
                end else begin
                  step_q  <= SP_X2;
                  state_q <= ST_RD;
                end
              end
              default: ;
            endcase
          end
        end
        ST_RD: begin
          state_q <= ST_MULGO;
        end
        ST_MULGO: begin
          state_q <= ST_MULW;
        end
        ST_MULW: begin
          if (mul_done) begin
            unique case (step_q)
              SP_X2: begin
                sxx_q   <= sxx_q + SQW'(prod);
                step_q  <= SP_XY;
                state_q <= ST_MULGO;
              end
              SP_XY: begin
                sxy_q   <= sxy_q + SQW'(prod);
                step_q  <= SP_Y2;
                state_q <= ST_MULGO;
              end
              SP_Y2: begin
                syy_q <= syy_q + SQW'(prod);
                sx_q  <= sx_q + SXW'(x_ext);
                sy_q  <= sy_q + SXW'(y_ext);
                if (idx_nxt < n_q) begin
                  idx_q   <= idx_nxt;
                  step_q  <= SP_X2;
                  state_q <= ST_RD;
                end else begin
                  step_q  <= SP_D1;
                  state_q <= ST_MULGO;
                end
              end
              SP_D1: begin
                tmp_q   <= prod;
                step_q  <= SP_D2;
                state_q <= ST_MULGO;
              end
              SP_D2: begin
                den_q <= tmp_q - prod;
                if (tmp_q == prod) begin
                  // all raw values equal
                  state_q <= ST_FIN;
                end else begin
                  degen_w_q <= 1'b0;
                  step_q    <= SP_N1;
                  state_q   <= ST_MULGO;
                end
              end
              SP_N1: begin
                tmp_q   <= prod;
                step_q  <= SP_N2;
                state_q <= ST_MULGO;
              end
              SP_N2: begin
                num_q   <= tmp_q - prod;
                step_q  <= SP_SL;
                state_q <= ST_DIVGO;
              end
              SP_O1: begin
                tmp_q   <= (sy_ext << 24) - prod;
                step_q  <= SP_OF;
                state_q <= ST_DIVGO;
              end
              SP_R1: begin
                d_q     <= (y_ext << 24) - prod - (off_ext << 24);
                state_q <= ST_RES1;
              end
              SP_R2: begin
                ssr_q <= ssr_q + prod;
                if (idx_nxt < n_q) begin
                  idx_q   <= idx_nxt;
                  step_q  <= SP_R1;
                  state_q <= ST_RD;
                end else begin
                  step_q  <= SP_T1;
                  state_q <= ST_MULGO;
                end
              end
              SP_T1: begin
                tmp_q   <= prod;
                step_q  <= SP_T2;
                state_q <= ST_MULGO;
              end
              SP_T2: begin
                tmp_q   <= tmp_q - prod;
                state_q <= ST_CHK;
              end
              SP_Q1: begin
                if (prod < tmp_q) begin
                  num_q   <= (tmp_q - prod) << 16;
                  step_q  <= SP_QD;
                  state_q <= ST_DIVGO;
                end else begin
                  state_q <= ST_FIN;
                end
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_RES1: begin
          rm_q    <= rnd_sum[W-1:24];
          dneg_q  <= d_q[W-1];
          state_q <= ST_RES2;
        end
        ST_RES2: begin
          e_q     <= dneg_q ? (~rm_q[63:0] + 64'd1) : rm_q[63:0];
          step_q  <= SP_R2;
          state_q <= ST_MULGO;
        end
        ST_CHK: begin
          // total variation must be positive and above the residual sum
          if ((tmp_q != '0) && !tmp_q[W-1] && (ssr_q < tmp_q)) begin
            step_q  <= SP_Q1;
            state_q <= ST_MULGO;
          end else begin
            state_q <= ST_FIN;
          end
        end
        ST_DIVGO: begin
          state_q <= ST_DIVW;
        end
        ST_DIVW: begin
          if (div_done) begin
            unique case (step_q)
              SP_SL: begin
                slope_w_q <= sat48(quo);
                step_q    <= SP_O1;
                state_q   <= ST_MULGO;
              end
              SP_OF: begin
                offset_w_q <= sat32(quo);
                idx_q      <= '0;
                ssr_q      <= '0;
                step_q     <= SP_R1;
                state_q    <= ST_RD;
              end
              SP_QD: begin
                qual_w_q <= quo[16:0];
                state_q  <= ST_FIN;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            point_count_q <= 9'(n_q);
            slope_q       <= slope_w_q;
            offset_q      <= offset_w_q;
            quality_q     <= qual_w_q;
            degen_q       <= degen_w_q;
            out_valid_q   <= 1'b1;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign point_count_o = point_count_q;
  assign slope_o       = slope_q;
  assign offset_o      = offset_q;
  assign fit_quality_o = quality_q;
  assign degenerate_o  = degen_q;

endmodule

`default_nettype wire

// ----- rtl/core/lsf_checker.sv -----
// ----------------------------------------------------------------------------
// lsf_checker
// port-level checks for the least squares line fit unit, bound to the top
// ----------------------------------------------------------------------------
`default_nettype none

module lsf_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [1:0]  opcode_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [8:0]  point_count_o,
  input wire logic [47:0] slope_o,
  input wire logic [31:0] offset_o,
  input wire logic [16:0] fit_quality_o,
  input wire logic        degenerate_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(slope_o) &&
    $stable(offset_o) && $stable(fit_quality_o) && $stable(point_count_o))
    else $error("result changed while stalled");

  // degenerate fits report the identity line
  a_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> slope_o == lsf_pkg::ONE_Q24 &&
    offset_o == '0 && fit_quality_o == '0)
    else $error("degenerate result with non-default line");

  // r squared never above one
  a_quality: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fit_quality_o <= lsf_pkg::Q_ONE)
    else $error("fit quality above one");

  // a fit transaction keeps the input side busy
  a_fit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && opcode_i == lsf_pkg::OP_FIT |=> !in_ready_o)
    else $error("input ready right after a fit was taken");

endmodule

bind least_squares_line_fit_unit lsf_checker u_lsf_checker (.*);

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the least squares line fit unit: point appends,
// clears and fits on both channels go through a bit-exact line fit predictor
// and every fit result is compared field by field, in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    logic [8:0]         count;
    logic signed [47:0] slope;
    logic signed [31:0] offset;
    logic [16:0]        quality;
    logic               degen;
  } fit_result_t;

  localparam int WATCHDOG_LIMIT = 100000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] opcode_i = lsf_pkg::OP_APPEND;
  logic channel_i = 1'b0;
  logic signed [31:0] raw_value_i = '0;
  logic signed [31:0] actual_value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [8:0] point_count_o;
  logic signed [47:0] slope_o;
  logic signed [31:0] offset_o;
  logic [16:0] fit_quality_o;
  logic degenerate_o;

  least_squares_line_fit_unit u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .opcode_i, .channel_i,
    .raw_value_i, .actual_value_i, .out_valid_o, .out_ready_i, .point_count_o,
    .slope_o, .offset_o, .fit_quality_o, .degenerate_o
  );

  always #2 clk_i = ~clk_i;

  // predictor state
  logic signed [31:0] pts_raw[lsf_pkg::NUM_CHANNELS][lsf_pkg::MAX_POINTS_DEF];
  logic signed [31:0] pts_act[lsf_pkg::NUM_CHANNELS][lsf_pkg::MAX_POINTS_DEF];
  int held[lsf_pkg::NUM_CHANNELS];

  fit_result_t expected_fits[$];
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic in_accept;
  logic out_accept;

  // signed division rounded to nearest, ties away from zero
  function automatic wide_t div_nearest(wide_t a, wide_t b);
    wide_t ua, ub, q;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    if (ub == 0) return '0;
    q = (ua + (ub >>> 1)) / ub;
    return ((a < 0) != (b < 0)) ? -q : q;
  endfunction

  function automatic wide_t clamp_signed(wide_t v, int bits);
    wide_t hi, lo;
    hi = (wide_t'(1) <<< (bits - 1)) - 1;
    lo = -(wide_t'(1) <<< (bits - 1));
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic fit_result_t line_fit(int ch);
    fit_result_t r;
    wide_t n, sx, sy, sxx, sxy, syy, den, num, t, ssr, a, x, y, d, e, slope, offset;
    logic signed [63:0] sy_q24;
    r.count = held[ch][8:0];
    r.slope = 48'sd16777216;
    r.offset = '0;
    r.quality = '0;
    r.degen = 1'b1;
    n = held[ch];
    if (held[ch] < 2) return r;
    sx = 0; sy = 0; sxx = 0; sxy = 0; syy = 0; ssr = 0;
    for (int i = 0; i < held[ch]; i++) begin
      x = pts_raw[ch][i];
      y = pts_act[ch][i];
      sx += x; sy += y;
      sxx += x * x; sxy += x * y; syy += y * y;
    end
    den = n * sxx - sx * sx;
    if (den == 0) return r;
    r.degen = 1'b0;
    num = n * sxy - sx * sy;
    slope = clamp_signed(div_nearest(num <<< 24, den), 48);
    // the sum term is taken to 64 bits; for up to 256 points of 32 bits it always fits
    sy_q24 = 64'(sy <<< 24);
    t = wide_t'(sy_q24) - slope * sx;
    offset = clamp_signed(div_nearest(t, n <<< 24), 32);
    for (int i = 0; i < held[ch]; i++) begin
      x = pts_raw[ch][i];
      y = pts_act[ch][i];
      d = (y <<< 24) - slope * x - (offset <<< 24);
      e = wide_t'($signed(64'(div_nearest(d, wide_t'(1) <<< 24))));
      ssr += e * e;
    end
    t = n * syy - sy * sy;
    if (t > 0 && ssr < t) begin
      a = ssr * n;
      if (a < t) r.quality = 17'(div_nearest((t - a) <<< 16, t));
    end
    r.slope = slope[47:0];
    r.offset = offset[31:0];
    return r;
  endfunction

  task automatic apply_item(logic [1:0] op, logic ch, logic signed [31:0] xr,
                            logic signed [31:0] ya);
    if (op == lsf_pkg::OP_APPEND) begin
      if (held[ch] < lsf_pkg::MAX_POINTS_DEF) begin
        pts_raw[ch][held[ch]] = xr;
        pts_act[ch][held[ch]] = ya;
        held[ch]++;
      end
    end else if (op == lsf_pkg::OP_CLEAR) begin
      held[ch] = 0;
    end else if (op == lsf_pkg::OP_FIT) begin
      expected_fits = {expected_fits, line_fit(ch)};
    end
  endtask

  task automatic send_item(logic [1:0] op, logic ch, logic signed [31:0] xr,
                           logic signed [31:0] ya);
    int gap;
    in_valid_i <= 1'b1;
    opcode_i <= op;
    channel_i <= ch;
    raw_value_i <= xr;
    actual_value_i <= ya;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    apply_item(op, ch, xr, ya);
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic signed [31:0] any_value();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
      2: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return $signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000;
    endcase
  endfunction

  // output side: random back-pressure plus in-order comparison
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    fit_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_fits.size() == 0) begin
        $error("fit result with nothing expected");
        fail_count++;
      end else begin
        want = expected_fits.pop_front();
        if (point_count_o !== want.count) begin
          $error("point_count exp %0d got %0d", want.count, point_count_o);
          fail_count++;
        end
        if (slope_o !== want.slope) begin
          $error("slope exp %0d got %0d", want.slope, slope_o);
          fail_count++;
        end
        if (offset_o !== want.offset) begin
          $error("offset exp %0d got %0d", want.offset, offset_o);
          fail_count++;
        end
        if (fit_quality_o !== want.quality) begin
          $error("fit_quality exp %0d got %0d", want.quality, fit_quality_o);
          fail_count++;
        end
        if (degenerate_o !== want.degen) begin
          $error("degenerate exp %0d got %0d", want.degen, degenerate_o);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  int quiet_cycles = 0;
  assign in_accept = in_valid_i && in_ready_o;
  assign out_accept = out_valid_o && out_ready_i;

  always @(posedge clk_i) begin
    if (in_accept || out_accept) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL least_squares_line_fit_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_directed();
    send_item(lsf_pkg::OP_FIT, 1'b0, 0, 0);              // empty channel
    send_item(lsf_pkg::OP_APPEND, 1'b0, 32'sh0001_0000, 32'sh0002_0000);
    send_item(lsf_pkg::OP_FIT, 1'b0, 0, 0);              // single point
    send_item(lsf_pkg::OP_APPEND, 1'b0, 32'sh0001_0000, 32'sh0005_0000);
    send_item(lsf_pkg::OP_FIT, 1'b0, 0, 0);              // all raw equal, zero denominator
    send_item(lsf_pkg::OP_APPEND, 1'b0, 32'sh0003_0000, 32'sh0006_0000);
    send_item(lsf_pkg::OP_FIT, 1'b0, 0, 0);
    send_item(lsf_pkg::OP_CLEAR, 1'b0, 0, 0);
    send_item(lsf_pkg::OP_APPEND, 1'b1, 32'sh7fff_ffff, 32'sh8000_0000);
    send_item(lsf_pkg::OP_APPEND, 1'b1, 32'sh8000_0000, 32'sh7fff_ffff);
    send_item(lsf_pkg::OP_APPEND, 1'b1, 32'sh0000_0000, 32'shffff_ffff);
    send_item(lsf_pkg::OP_FIT, 1'b1, 0, 0);              // extreme values
    send_item(lsf_pkg::OP_CLEAR, 1'b1, 0, 0);
    send_item(lsf_pkg::OP_APPEND, 1'b1, 32'sh0000_0001, 32'sh7fff_ffff);
    send_item(lsf_pkg::OP_APPEND, 1'b1, 32'sh0000_0002, 32'sh8000_0000);
    send_item(lsf_pkg::OP_FIT, 1'b1, 0, 0);              // steep slope, saturates
    send_item(lsf_pkg::OP_RESERVED, 1'b1, 32'sh1234_5678, 0);
    send_item(lsf_pkg::OP_FIT, 1'b1, 0, 0);
    send_item(lsf_pkg::OP_FIT, 1'b0, 0, 0);              // cleared channel
    send_item(lsf_pkg::OP_CLEAR, 1'b1, 0, 0);
  endtask

  task automatic test_full_channel();
    int k;
    k = $urandom_range(-300, 300);
    for (int i = 0; i < lsf_pkg::MAX_POINTS_DEF + 2; i++)
      send_item(lsf_pkg::OP_APPEND, 1'b1,
                32'sh0010_0000 * (i - 128) + $urandom_range(255),
                32'sh8000 * k + i * 32'sh1_0000);
    send_item(lsf_pkg::OP_FIT, 1'b1, 0, 0);              // full, extra points dropped
    send_item(lsf_pkg::OP_CLEAR, 1'b1, 0, 0);
  endtask

  task automatic test_random(int items);
    logic ch;
    logic signed [31:0] xr, ya;
    int k;
    for (int i = 0; i < items; i++) begin
      ch = $urandom_range(1);
      case ($urandom_range(15))
        0, 1: send_item(lsf_pkg::OP_FIT, ch, $urandom, $urandom);
        2: send_item(held[ch] > 12 ? lsf_pkg::OP_CLEAR : lsf_pkg::OP_FIT, ch,
                     $urandom, $urandom);
        3: send_item(lsf_pkg::OP_RESERVED, ch, $urandom, $urandom);
        4, 5, 6: send_item(lsf_pkg::OP_APPEND, ch, any_value(), any_value());
        default: begin
          // points near a line, for a meaningful r squared
          k = $urandom_range(-2048, 2048);
          xr = $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
          ya = (xr * k) >>> 8;
          ya = ya + $signed($urandom_range(32'h0000_4000)) - 32'sh2000;
          send_item(lsf_pkg::OP_APPEND, ch, xr, ya);
        end
      endcase
      if (held[ch] > 24) send_item(lsf_pkg::OP_CLEAR, ch, 0, 0);
    end
  endtask

  initial begin
    held[0] = 0;
    held[1] = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 16;
    recv_stall_pct = 88;
    test_directed();
    test_random(90);
    send_idle_pct = 88;
    recv_stall_pct = 16;
    test_full_channel();
    test_random(90);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(100);
    in_valid_i <= 1'b0;
    while (expected_fits.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS least_squares_line_fit_unit");
    end else begin
      $display("FAIL least_squares_line_fit_unit");
    end
    $finish;
  end

endmodule

// ----- least_squares_line_fit_unit.f -----
rtl/core/lsf_pkg.sv
rtl/core/lsf_mul.sv
rtl/core/lsf_div.sv
rtl/core/least_squares_line_fit_unit.sv
rtl/core/lsf_checker.sv
tb/tb_top.sv
